@@ rtl/rsb_pkg.sv @@
package rsb_pkg;

  localparam int VALUE_W     = 8;
  localparam int MAX_ITEMS   = 64;
  localparam int KEY_BITS    = 8;

  localparam int IDX_W       = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
  localparam int PASS_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one queued input item
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } q_item_t;

  // sort engine status, seen by the top level
  typedef struct packed {
    logic loading;
    logic emitting;
  } stat_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_COUNT,
    ST_SCATTER,
    ST_EMIT
  } sort_state_t;

  // key bit of a pass; passes past the byte see zero
  function automatic logic key_bit(logic [VALUE_W-1:0] v, logic [PASS_W-1:0] p);
    logic [VALUE_W-1:0] sh;
    sh = v >> p;
    return sh[0];
  endfunction

endpackage

@@ rtl/rsb_ifs.sv @@
interface rsb_in_if;
  import rsb_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface rsb_out_if;
  import rsb_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] sorted_value;
  logic               end_of_set;

  modport source (output valid, output sorted_value, output end_of_set, input ready);
  modport sink   (input valid, input sorted_value, input end_of_set, output ready);
endinterface

@@ rtl/binary_lsd_radix_sort_bytes_top.sv @@
// Binary LSD radix sort of a set of bytes.
// in_ch  : one byte per item (value), last = 1 closes the set and starts the sort.
//          Up to 64 bytes are kept; bytes past that are dropped, also one carrying
//          last, and the sort still runs on what is stored.
// out_ch : the stored bytes in ascending order, one per item, end_of_set = 1 on the
//          final one. Results appear only after a set is closed.
// A two-item queue sits between the input side and the sort engine, so the input
// keeps taking items while the engine is busy until the queue fills.
// Flow for a set of stored bytes: the engine stores each queued item while loading.
// The sort makes eight passes over two buffer RAMs, each pass a counting walk and a
// scatter walk over the stored bytes. The output then streams one item per cycle
// while the receiver is ready; the two buffer walks per key bit take most of the
// time of a set. The first result comes only after all eight passes are done.
// A stalled receiver holds the current result and pauses the output walk; new
// items wait in the queue until the whole set has been delivered.
// Reset (rst, synchronous) empties the queue, clears the byte count and drops any
// set in progress; buffer contents are not cleared and need not be.
module binary_lsd_radix_sort_bytes_top (
  input  logic      clk,
  input  logic      rst,
  rsb_in_if.sink    in_ch,
  rsb_out_if.source out_ch
);
  import rsb_pkg::*;

  logic    q_valid;
  logic    q_ready;
  q_item_t q_item;
  stat_t   bstat;

  // input side: handshake and item queue
  rsb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  // sort engine: buffers, counting and scatter passes, result stream
  rsb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .out_ch  (out_ch),
    .status  (bstat)
  );

  // results only while the engine streams the sorted set
  a_out_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> bstat.emitting)
    else $error("result shown outside the output phase");

  // engine takes items from the queue only while loading
  a_pop_in_load: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |-> bstat.loading)
    else $error("queue popped while sorting or emitting");

  // a full queue always offers an item to the engine
  a_full_has_item: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> q_valid)
    else $error("input stalled with an empty queue");

  // nothing follows the final byte of a set right away
  a_eos_closes: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.end_of_set) |=> !out_ch.valid)
    else $error("result after end of set");

endmodule

@@ rtl/rsb_ram.sv @@
module rsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/rsb_front.sv @@
module rsb_front (
  input  logic            clk,
  input  logic            rst,
  rsb_in_if.sink          in_ch,
  output logic            q_valid,
  input  logic            q_ready,
  output rsb_pkg::q_item_t q_item
);
  import rsb_pkg::*;

  q_item_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;

  assign in_ch.ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign q_valid     = (fill != '0);
  assign q_item      = entries[rd_ptr];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{value: in_ch.value, last: in_ch.last};
    end
  end

endmodule

@@ rtl/rsb_back.sv @@
module rsb_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  rsb_pkg::q_item_t q_item,
  rsb_out_if.source        out_ch,
  output rsb_pkg::stat_t   status
);
  import rsb_pkg::*;

  sort_state_t        state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [CNT_W-1:0]   n, n_next;
  logic [CNT_W-1:0]   idx, idx_next;
  logic [CNT_W-1:0]   zeros, zeros_next;
  logic [CNT_W-1:0]   slot0, slot0_next;
  logic [CNT_W-1:0]   slot1, slot1_next;
  logic [PASS_W-1:0]  pass, pass_next;
  logic               src_sel, src_sel_next;
  logic               pend, pend_next;
  logic               out_valid, out_valid_next;
  logic               eos, eos_next;

  logic [CNT_W-1:0]   idx_inc;
  logic               idx_more;
  logic               out_free;
  logic               kb;

  // buffer 0 is the primary buffer, buffer 1 the scratch buffer
  logic               wr_en, wr_sel, rd_en, rd_sel;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [VALUE_W-1:0] rdata0, rdata1, src_rdata;

  rsb_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_primary (
    .clk   (clk),
    .we    (wr_en && !wr_sel),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en && !rd_sel),
    .raddr (rd_addr),
    .rdata (rdata0)
  );

  rsb_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_scratch (
    .clk   (clk),
    .we    (wr_en && wr_sel),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en && rd_sel),
    .raddr (rd_addr),
    .rdata (rdata1)
  );

  assign src_rdata = src_sel ? rdata1 : rdata0;
  assign kb        = key_bit(src_rdata, pass);
  assign idx_inc   = idx + CNT_W'(1);
  assign idx_more  = (idx < n);
  assign out_free  = !out_valid || out_ch.ready;

  assign q_ready             = (state == ST_LOAD);
  assign out_ch.valid        = out_valid;
  assign out_ch.sorted_value = src_rdata;
  assign out_ch.end_of_set   = eos;
  assign status.loading      = (state == ST_LOAD);
  assign status.emitting     = (state == ST_EMIT);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    n_next         = n;
    idx_next       = idx;
    zeros_next     = zeros;
    slot0_next     = slot0;
    slot1_next     = slot1;
    pass_next      = pass;
    src_sel_next   = src_sel;
    pend_next      = 1'b0;
    out_valid_next = out_valid;
    eos_next       = eos;
    wr_en          = 1'b0;
    wr_sel         = 1'b0;
    wr_addr        = '0;
    wr_data        = q_item.value;
    rd_en          = 1'b0;
    rd_sel         = src_sel;
    rd_addr        = idx[IDX_W-1:0];

    case (state)
      ST_LOAD: begin
        if (q_valid) begin
          if (cnt < CNT_W'(MAX_ITEMS)) begin
            wr_en    = 1'b1;
            wr_addr  = cnt[IDX_W-1:0];
            cnt_next = cnt + CNT_W'(1);
          end
          if (q_item.last) begin
            n_next       = (cnt < CNT_W'(MAX_ITEMS)) ? cnt + CNT_W'(1) : cnt;
            idx_next     = '0;
            zeros_next   = '0;
            pass_next    = '0;
            src_sel_next = 1'b0;
            state_next   = ST_COUNT;
          end
        end
      end

      ST_COUNT: begin
        if (idx_more) begin
          rd_en     = 1'b1;
          idx_next  = idx_inc;
          pend_next = 1'b1;
        end
        if (pend && !kb) begin
          zeros_next = zeros + CNT_W'(1);
        end
        if (!idx_more && !pend) begin
          slot0_next = '0;
          slot1_next = zeros;
          idx_next   = '0;
          state_next = ST_SCATTER;
        end
      end

      ST_SCATTER: begin
        if (idx_more) begin
          rd_en     = 1'b1;
          idx_next  = idx_inc;
          pend_next = 1'b1;
        end
        if (pend) begin
          wr_en   = 1'b1;
          wr_sel  = !src_sel;
          wr_data = src_rdata;
          if (kb) begin
            wr_addr    = slot1[IDX_W-1:0];
            slot1_next = slot1 + CNT_W'(1);
          end else begin
            wr_addr    = slot0[IDX_W-1:0];
            slot0_next = slot0 + CNT_W'(1);
          end
        end
        if (!idx_more && !pend) begin
          idx_next     = '0;
          zeros_next   = '0;
          src_sel_next = !src_sel;
          if (pass == PASS_W'(KEY_BITS - 1)) begin
            state_next = ST_EMIT;
          end else begin
            pass_next  = pass + PASS_W'(1);
            state_next = ST_COUNT;
          end
        end
      end

      ST_EMIT: begin
        // RAM read register doubles as the output register
        if (idx_more && out_free) begin
          rd_en          = 1'b1;
          idx_next       = idx_inc;
          eos_next       = (idx_inc == n);
          out_valid_next = 1'b1;
        end else if (out_ch.ready) begin
          out_valid_next = 1'b0;
        end
        if (!idx_more && out_free) begin
          cnt_next   = '0;
          state_next = ST_LOAD;
        end
      end

      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      cnt       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    n       <= n_next;
    idx     <= idx_next;
    zeros   <= zeros_next;
    slot0   <= slot0_next;
    slot1   <= slot1_next;
    pass    <= pass_next;
    src_sel <= src_sel_next;
    eos     <= eos_next;
  end

endmodule
